@@ rtl/usbrxd_pkg.sv @@
package usbrxd_pkg;

    // frame format
    localparam int LENGTH_BITS        = 14;
    localparam int STATUS_BYTES       = 4;
    localparam int CRC_BYTES          = 4;
    localparam int LEN_LSB            = 16;
    localparam int PAD_MASK           = 3;
    localparam int MAX_TRANSFER_BYTES = 16384;

    // port widths
    localparam int BYTE_W      = 8;
    localparam int XFER_SIZE_W = 15;
    localparam int OUT_LEN_W   = 14;
    localparam int CNT_W       = 32;
    localparam int STATUS_W    = 32;
    localparam int MIN_W       = 8;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // register map
    typedef enum logic [1:0] {
        REG_ERR_MASK  = 2'd0,
        REG_MAX_FRAME = 2'd1,
        REG_MIN_FRAME = 2'd2
    } t_reg_idx;

    localparam logic [STATUS_W-1:0]    ERR_MASK_RST  = 32'h0000_8000;
    localparam logic [LENGTH_BITS-1:0] MAX_FRAME_RST = LENGTH_BITS'(1522);
    localparam logic [MIN_W-1:0]       MIN_FRAME_RST = MIN_W'(18);

    // deframer phase
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_SKIP    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [STATUS_W-1:0]    err_mask;
        logic [LENGTH_BITS-1:0] max_frame;
        logic [MIN_W-1:0]       min_frame;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]      data_byte;
        logic                   start_of_transfer;
        logic [XFER_SIZE_W-1:0] transfer_size;
        logic                   transfer_failed;
        logic                   queue_full;
    } t_in_item;

    typedef struct packed {
        logic                 valid;
        logic [BYTE_W-1:0]    data;
        logic                 first;
        logic                 last;
        logic [OUT_LEN_W-1:0] length;
    } t_payload;

endpackage

@@ rtl/usbrxd_cfg.sv @@
module usbrxd_cfg
    import usbrxd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [STATUS_W-1:0]    r_err_mask;
    logic [LENGTH_BITS-1:0] r_max_frame;
    logic [MIN_W-1:0]       r_min_frame;
    logic                   wr_en;
    t_reg_idx               reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_mask  <= ERR_MASK_RST;
            r_max_frame <= MAX_FRAME_RST;
            r_min_frame <= MIN_FRAME_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ERR_MASK:  r_err_mask  <= pwdata[STATUS_W-1:0];
                REG_MAX_FRAME: r_max_frame <= pwdata[LENGTH_BITS-1:0];
                REG_MIN_FRAME: r_min_frame <= pwdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            REG_ERR_MASK:  prdata = r_err_mask;
            REG_MAX_FRAME: prdata = APB_DATA_W'(r_max_frame);
            REG_MIN_FRAME: prdata = APB_DATA_W'(r_min_frame);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.err_mask  = r_err_mask;
    assign o_cfg.max_frame = r_max_frame;
    assign o_cfg.min_frame = r_min_frame;

endmodule

@@ rtl/usbrxd_core.sv @@
module usbrxd_core
    import usbrxd_pkg::*;
#(
    parameter int MAX_XFER_BYTES = MAX_TRANSFER_BYTES
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  t_in_item         i_item,
    input  t_cfg             i_cfg,
    output t_payload         o_result,
    output logic [CNT_W-1:0] o_error_count,
    output logic [CNT_W-1:0] o_overrun_count,
    output logic [CNT_W-1:0] o_transfer_count
);

    localparam int TL_W = $clog2(MAX_XFER_BYTES + 1);
    localparam int CW   = ((TL_W > LENGTH_BITS) ? TL_W : LENGTH_BITS) + 1;
    localparam int SK_W = LENGTH_BITS + 1;
    localparam int SZ_W = ((TL_W > XFER_SIZE_W) ? TL_W : XFER_SIZE_W) + 1;

    t_phase                 r_phase, n_phase;
    logic [STATUS_W-1:0]    r_status, n_status;
    logic [1:0]             r_hbs, n_hbs;
    logic [TL_W-1:0]        r_tl, n_tl;
    logic [LENGTH_BITS-1:0] r_pl, n_pl;
    logic [SK_W-1:0]        r_skip, n_skip;
    logic [LENGTH_BITS-1:0] r_fpl, n_fpl;
    logic [CNT_W-1:0]       r_err, n_err;
    logic [CNT_W-1:0]       r_ovr, n_ovr;
    logic [CNT_W-1:0]       r_xfer, n_xfer;

    // state as seen by the byte, after a transfer start is applied
    t_phase                 e_phase;
    logic [STATUS_W-1:0]    e_status;
    logic [1:0]             e_hbs;
    logic [TL_W-1:0]        e_tl;
    logic [LENGTH_BITS-1:0] e_pl;
    logic [SK_W-1:0]        e_skip;

    logic [STATUS_W-1:0]    status_full;
    logic [LENGTH_BITS-1:0] len;
    logic [SK_W-1:0]        padded;
    logic [LENGTH_BITS-1:0] body_len;
    logic [TL_W-1:0]        tl_dec;
    logic                   short_tail;
    logic                   bad;
    logic                   sat;

    assign sat = SZ_W'(i_item.transfer_size) > SZ_W'(MAX_XFER_BYTES);

    // header field decode
    assign status_full = e_status | (STATUS_W'(i_item.data_byte) << {e_hbs, 3'b000});
    assign len         = status_full[LEN_LSB +: LENGTH_BITS];
    assign padded      = (SK_W'(len) + SK_W'(PAD_MASK)) & ~SK_W'(PAD_MASK);
    assign body_len    = len - LENGTH_BITS'(CRC_BYTES);
    assign tl_dec      = e_tl - TL_W'(1);
    assign short_tail  = (TL_W+1)'(e_tl)
                       < ((TL_W+1)'(i_cfg.min_frame) + (TL_W+1)'(STATUS_BYTES));
    assign bad = ((status_full & i_cfg.err_mask) != '0)
              || (CW'(len) > CW'(tl_dec))
              || (len > i_cfg.max_frame)
              || (len < LENGTH_BITS'(i_cfg.min_frame))
              || (len <= LENGTH_BITS'(CRC_BYTES));

    // per byte state update
    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_hbs    = r_hbs;
        n_tl     = r_tl;
        n_pl     = r_pl;
        n_skip   = r_skip;
        n_fpl    = r_fpl;
        n_err    = r_err;
        n_ovr    = r_ovr;
        n_xfer   = r_xfer;
        o_result = '0;

        e_phase  = r_phase;
        e_status = r_status;
        e_hbs    = r_hbs;
        e_tl     = r_tl;
        e_pl     = r_pl;
        e_skip   = r_skip;

        // a start item opens a fresh transfer
        if (i_item.start_of_transfer) begin
            n_xfer   = r_xfer + CNT_W'(1);
            e_phase  = PH_HEADER;
            e_status = '0;
            e_hbs    = '0;
            e_pl     = '0;
            e_skip   = '0;
            e_tl     = sat ? TL_W'(MAX_XFER_BYTES) : TL_W'(i_item.transfer_size);
        end

        if (i_item.start_of_transfer && i_item.transfer_failed) begin
            n_err    = r_err + CNT_W'(1);
            n_phase  = PH_IDLE;
            n_tl     = '0;
            n_status = '0;
            n_hbs    = '0;
            n_pl     = '0;
            n_skip   = '0;
        end else if (!i_item.transfer_failed) begin
            n_phase  = e_phase;
            n_status = e_status;
            n_hbs    = e_hbs;
            n_tl     = e_tl;
            n_pl     = e_pl;
            n_skip   = e_skip;
            if (e_phase == PH_IDLE || e_tl == '0) begin
                n_phase = PH_IDLE;
            end else begin
                case (e_phase)
                    PH_HEADER: begin
                        if (e_hbs == '0 && short_tail) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_status = status_full;
                            n_hbs    = e_hbs + 2'd1;
                            n_tl     = tl_dec;
                            if (e_hbs == 2'(STATUS_BYTES - 1)) begin
                                if (bad || i_item.queue_full) begin
                                    if (bad) begin
                                        n_err = r_err + CNT_W'(1);
                                    end else begin
                                        n_ovr = r_ovr + CNT_W'(1);
                                    end
                                    n_skip = padded;
                                    if (padded != '0) begin
                                        n_phase = PH_SKIP;
                                    end else begin
                                        n_phase  = PH_HEADER;
                                        n_status = '0;
                                        n_hbs    = '0;
                                        n_pl     = '0;
                                        n_skip   = '0;
                                    end
                                end else begin
                                    n_fpl   = body_len;
                                    n_pl    = body_len;
                                    n_skip  = padded - SK_W'(body_len);
                                    n_phase = PH_PAYLOAD;
                                end
                            end
                            if (tl_dec == '0) begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                    PH_PAYLOAD: begin
                        o_result.valid = 1'b1;
                        o_result.data  = i_item.data_byte;
                        o_result.first = (e_pl == r_fpl);
                        if (e_pl == LENGTH_BITS'(1)) begin
                            o_result.last   = 1'b1;
                            o_result.length = OUT_LEN_W'(r_fpl);
                        end
                        n_pl = e_pl - LENGTH_BITS'(1);
                        n_tl = tl_dec;
                        if (n_pl == '0) begin
                            if (e_skip != '0) begin
                                n_phase = PH_SKIP;
                            end else begin
                                n_phase  = PH_HEADER;
                                n_status = '0;
                                n_hbs    = '0;
                                n_skip   = '0;
                            end
                        end
                        if (tl_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    PH_SKIP: begin
                        n_skip = e_skip - SK_W'(1);
                        n_tl   = tl_dec;
                        if (n_skip == '0) begin
                            n_phase  = PH_HEADER;
                            n_status = '0;
                            n_hbs    = '0;
                            n_pl     = '0;
                        end
                        if (tl_dec == '0) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_status <= '0;
            r_hbs    <= '0;
            r_tl     <= '0;
            r_pl     <= '0;
            r_skip   <= '0;
            r_fpl    <= '0;
            r_err    <= '0;
            r_ovr    <= '0;
            r_xfer   <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_status <= n_status;
            r_hbs    <= n_hbs;
            r_tl     <= n_tl;
            r_pl     <= n_pl;
            r_skip   <= n_skip;
            r_fpl    <= n_fpl;
            r_err    <= n_err;
            r_ovr    <= n_ovr;
            r_xfer   <= n_xfer;
        end
    end

    assign o_error_count    = r_err;
    assign o_overrun_count  = r_ovr;
    assign o_transfer_count = r_xfer;

endmodule

@@ rtl/usb_rx_ethernet_deframer_top.sv @@
// USB bulk-in Ethernet deframer. Takes one transfer byte per item and gives
// exactly one result item per input item, in order: a payload byte with
// first/last marks and the frame length on the last byte, or an empty payload,
// plus the error, overrun and transfer counters as they stand after that item.
// Each frame opens with a 4-byte little-endian status word; flagged, oversized,
// undersized or truncated frames are dropped and counted as errors, frames that
// meet a full queue are dropped and counted as overruns, and CRC plus padding to
// 4 bytes are skipped. Throughput is one item per clock while the result is not
// stalled; an accepted item lands in the input register, and the single state
// update then loads its result into the result register.
// A stalled result holds both registers and stalls the input.
// Configuration registers at byte
// offsets 0x0 (error flag mask), 0x4 (max frame bytes), 0x8 (min frame bytes)
// are to be written only while no item is in flight.
module usb_rx_ethernet_deframer_top
    import usbrxd_pkg::*;
#(
    parameter int MAX_XFER_BYTES = MAX_TRANSFER_BYTES
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // input channel
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [BYTE_W-1:0]      i_data_byte,
    input  logic                   i_start_of_transfer,
    input  logic [XFER_SIZE_W-1:0] i_transfer_size,
    input  logic                   i_transfer_failed,
    input  logic                   i_queue_full,
    // result channel
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic                   o_payload_valid,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic                   o_payload_first,
    output logic                   o_payload_last,
    output logic [OUT_LEN_W-1:0]   o_payload_length,
    output logic [CNT_W-1:0]       o_error_count,
    output logic [CNT_W-1:0]       o_overrun_count,
    output logic [CNT_W-1:0]       o_transfer_count
);

    t_cfg     cfg;
    t_in_item r_in;
    logic     r_in_valid;
    t_payload r_out;
    logic     r_out_valid;
    t_payload result;
    logic     advance;
    logic     step;

    usbrxd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // pipeline moves when the result register is free or being taken
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign step    = advance && r_in_valid;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in.data_byte         <= i_data_byte;
            r_in.start_of_transfer <= i_start_of_transfer;
            r_in.transfer_size     <= i_transfer_size;
            r_in.transfer_failed   <= i_transfer_failed;
            r_in.queue_full        <= i_queue_full;
        end
    end

    usbrxd_core #(
        .MAX_XFER_BYTES (MAX_XFER_BYTES)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_item           (r_in),
        .i_cfg            (cfg),
        .o_result         (result),
        .o_error_count    (o_error_count),
        .o_overrun_count  (o_overrun_count),
        .o_transfer_count (o_transfer_count)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_payload_valid  = r_out.valid;
    assign o_payload_byte   = r_out.data;
    assign o_payload_first  = r_out.first;
    assign o_payload_last   = r_out.last;
    assign o_payload_length = r_out.length;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import usbrxd_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [STATUS_W-1:0] LEN_FIELD =
        STATUS_W'((1 << LENGTH_BITS) - 1) << LEN_LSB;

    // one result item as the block should present it
    typedef struct packed {
        t_payload         pl;
        logic [CNT_W-1:0] errors;
        logic [CNT_W-1:0] overruns;
        logic [CNT_W-1:0] transfers;
    } deframe_out_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [BYTE_W-1:0]      i_data_byte = '0;
    logic                   i_start_of_transfer = 1'b0;
    logic [XFER_SIZE_W-1:0] i_transfer_size = '0;
    logic                   i_transfer_failed = 1'b0;
    logic                   i_queue_full = 1'b0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic                   o_payload_valid;
    logic [BYTE_W-1:0]      o_payload_byte;
    logic                   o_payload_first;
    logic                   o_payload_last;
    logic [OUT_LEN_W-1:0]   o_payload_length;
    logic [CNT_W-1:0]       o_error_count;
    logic [CNT_W-1:0]       o_overrun_count;
    logic [CNT_W-1:0]       o_transfer_count;

    // idling controls
    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;
    bit   sender_calm = 1'b0;
    bit   rx_calm = 1'b0;
    logic [5:0] stall_epoch = '0;

    int   items_sent = 0;
    int   mismatch_count = 0;
    deframe_out_t predicted_outputs[$];

    // deframer shadow state and configuration
    logic [STATUS_W-1:0] cfg_err_mask = ERR_MASK_RST;
    int                  cfg_max_frame = int'(MAX_FRAME_RST);
    int                  cfg_min_frame = int'(MIN_FRAME_RST);
    t_phase              df_phase = PH_IDLE;
    logic [STATUS_W-1:0] status_acc = '0;
    int                  hdr_seen = 0;
    int                  xfer_left = 0;
    int                  body_left = 0;
    int                  skip_left = 0;
    int                  body_len = 0;
    logic [CNT_W-1:0]    err_cnt = '0;
    logic [CNT_W-1:0]    ovr_cnt = '0;
    logic [CNT_W-1:0]    xfer_cnt = '0;

    usb_rx_ethernet_deframer_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .i_start_of_transfer (i_start_of_transfer),
        .i_transfer_size     (i_transfer_size),
        .i_transfer_failed   (i_transfer_failed),
        .i_queue_full        (i_queue_full),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_payload_valid     (o_payload_valid),
        .o_payload_byte      (o_payload_byte),
        .o_payload_first     (o_payload_first),
        .o_payload_last      (o_payload_last),
        .o_payload_length    (o_payload_length),
        .o_error_count       (o_error_count),
        .o_overrun_count     (o_overrun_count),
        .o_transfer_count    (o_transfer_count)
    );

    always #4 i_clk = ~i_clk;

    // prepare for the next status word
    function automatic void open_header();
        df_phase   = PH_HEADER;
        status_acc = '0;
        hdr_seen   = 0;
        body_left  = 0;
        skip_left  = 0;
    endfunction

    // frame body done or dropped: skip crc and padding, else next header
    function automatic void end_body();
        if (skip_left > 0) begin
            df_phase = PH_SKIP;
        end else begin
            open_header();
        end
    endfunction

    // one data byte through the deframer
    function automatic t_payload consume_byte(logic [BYTE_W-1:0] data, logic qfull);
        t_payload pl;
        int       len;
        int       padded;
        bit       bad;
        pl = '0;
        if (df_phase == PH_IDLE || xfer_left == 0) begin
            df_phase = PH_IDLE;
            return pl;
        end
        case (df_phase)
            PH_HEADER: begin
                // tail too short for a minimal frame
                if (hdr_seen == 0 && xfer_left < STATUS_BYTES + cfg_min_frame) begin
                    df_phase = PH_IDLE;
                    return pl;
                end
                status_acc |= STATUS_W'(data) << (8 * hdr_seen);
                hdr_seen++;
                xfer_left--;
                if (hdr_seen >= STATUS_BYTES) begin
                    len    = int'(status_acc[LEN_LSB +: LENGTH_BITS]);
                    padded = (len + PAD_MASK) & ~PAD_MASK;
                    bad    = (status_acc & cfg_err_mask) != 0 || len > xfer_left
                          || len > cfg_max_frame || len < cfg_min_frame
                          || len <= CRC_BYTES;
                    if (bad) begin
                        err_cnt++;
                        skip_left = padded;
                        end_body();
                    end else if (qfull) begin
                        ovr_cnt++;
                        skip_left = padded;
                        end_body();
                    end else begin
                        body_len  = len - CRC_BYTES;
                        body_left = body_len;
                        skip_left = padded - body_len;
                        df_phase  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                pl.valid = 1'b1;
                pl.data  = data;
                pl.first = (body_left == body_len);
                if (body_left == 1) begin
                    pl.last   = 1'b1;
                    pl.length = OUT_LEN_W'(body_len);
                end
                body_left--;
                xfer_left--;
                if (body_left == 0) begin
                    end_body();
                end
            end
            default: begin
                skip_left--;
                xfer_left--;
                if (skip_left == 0) begin
                    open_header();
                end
            end
        endcase
        if (xfer_left == 0) begin
            df_phase = PH_IDLE;
        end
        return pl;
    endfunction

    // expected result of one accepted item
    function automatic deframe_out_t deframe_step(logic [BYTE_W-1:0] data, logic sot,
                                                  logic [XFER_SIZE_W-1:0] size,
                                                  logic failed, logic qfull);
        deframe_out_t r;
        r = '0;
        if (sot) begin
            xfer_cnt++;
            open_header();
            if (failed) begin
                err_cnt++;
                df_phase  = PH_IDLE;
                xfer_left = 0;
            end else begin
                xfer_left = (int'(size) > MAX_TRANSFER_BYTES) ? MAX_TRANSFER_BYTES
                                                              : int'(size);
                r.pl = consume_byte(data, qfull);
            end
        end else if (!failed) begin
            r.pl = consume_byte(data, qfull);
        end
        r.errors    = err_cnt;
        r.overruns  = ovr_cnt;
        r.transfers = xfer_cnt;
        return r;
    endfunction

    function automatic string describe(deframe_out_t r);
        return $sformatf("pv=%0d byte=%02h first=%0d last=%0d len=%0d err=%0d ovr=%0d xfer=%0d",
                         r.pl.valid, r.pl.data, r.pl.first, r.pl.last, r.pl.length,
                         r.errors, r.overruns, r.transfers);
    endfunction

    function automatic void report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s", msg);
        end
    endfunction

    // send one item, with random idle cycles ahead of it
    task automatic send_item(logic [BYTE_W-1:0] data, logic sot,
                             logic [XFER_SIZE_W-1:0] size, logic failed, logic qfull);
        while (!sender_calm && $urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid             <= 1'b1;
        i_data_byte         <= data;
        i_start_of_transfer <= sot;
        i_transfer_size     <= size;
        i_transfer_failed   <= failed;
        i_queue_full        <= qfull;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predicted_outputs.push_back(deframe_step(data, sot, size, failed, qfull));
        if (sot || !failed) begin
            items_sent++;
        end
    endtask

    // let every expected result come out, then settle
    task automatic wait_quiet();
        i_valid <= 1'b0;
        while (predicted_outputs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // apb write: setup then access
    task automatic write_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] wdata;
        wdata = $urandom();
        case (idx)
            REG_ERR_MASK:  wdata = value;
            REG_MAX_FRAME: wdata[LENGTH_BITS-1:0] = value[LENGTH_BITS-1:0];
            default:       wdata[MIN_W-1:0] = value[MIN_W-1:0];
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(idx));
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_ERR_MASK:  cfg_err_mask = wdata;
            REG_MAX_FRAME: cfg_max_frame = int'(wdata[LENGTH_BITS-1:0]);
            default:       cfg_min_frame = int'(wdata[MIN_W-1:0]);
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(logic [STATUS_W-1:0] mask, int max_len, int min_len);
        wait_quiet();
        write_reg(REG_ERR_MASK, mask);
        write_reg(REG_MAX_FRAME, APB_DATA_W'(max_len));
        write_reg(REG_MIN_FRAME, APB_DATA_W'(min_len));
    endtask

    // a transfer built from status-framed frames, some of them bad
    task automatic send_frame_transfer();
        logic [BYTE_W-1:0]   xfer_bytes[$];
        logic [STATUS_W-1:0] status;
        int                  nframes;
        int                  len;
        int                  span;
        int                  r;
        int                  xsize;
        bit                  runaway;
        runaway     = 1'b0;
        sender_calm = ($urandom_range(0, 4) == 0);
        nframes     = $urandom_range(1, 4);
        span        = cfg_max_frame - cfg_min_frame;
        if (span > 48) begin
            span = 48;
        end
        if (span < 0) begin
            span = 0;
        end
        for (int f = 0; f < nframes && !runaway; f++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                len = cfg_min_frame + $urandom_range(0, span);
            end else if (r < 85 && cfg_max_frame + 8 <= 16383) begin
                len = cfg_max_frame + $urandom_range(1, 8);
            end else if (r < 90) begin
                len = $urandom_range(0, CRC_BYTES);
            end else if (r < 94) begin
                len = $urandom_range(0, cfg_min_frame - 1);
            end else if (r < 97) begin
                len = (cfg_max_frame <= 1600) ? cfg_max_frame : cfg_min_frame;
            end else begin
                // length far beyond the transfer, ends the build
                len     = $urandom_range(2000, 16383);
                runaway = 1'b1;
            end
            status = $urandom();
            status[LEN_LSB +: LENGTH_BITS] = LENGTH_BITS'(len);
            if ($urandom_range(0, 3) != 0) begin
                status &= ~(cfg_err_mask & ~LEN_FIELD);
            end
            for (int k = 0; k < STATUS_BYTES; k++) begin
                xfer_bytes.push_back(status[8*k +: 8]);
            end
            if (runaway) begin
                repeat ($urandom_range(0, 8)) xfer_bytes.push_back(BYTE_W'($urandom()));
            end else begin
                repeat ((len + PAD_MASK) & ~PAD_MASK)
                    xfer_bytes.push_back(BYTE_W'($urandom()));
            end
        end
        // exact size, a short junk tail, or cut short
        r = $urandom_range(0, 99);
        if (r < 85 && r >= 70) begin
            repeat ($urandom_range(1, 3 + cfg_min_frame))
                xfer_bytes.push_back(BYTE_W'($urandom()));
        end else if (r >= 85) begin
            xsize = $urandom_range(1, xfer_bytes.size());
            while (xfer_bytes.size() > xsize) begin
                void'(xfer_bytes.pop_back());
            end
        end
        xsize = xfer_bytes.size();
        foreach (xfer_bytes[i]) begin
            if ($urandom_range(0, 99) < 3) begin
                send_item(BYTE_W'($urandom()), 1'b0, XFER_SIZE_W'($urandom()), 1'b1,
                          1'($urandom()));
            end
            send_item(xfer_bytes[i], i == 0,
                      (i == 0) ? XFER_SIZE_W'(xsize) : XFER_SIZE_W'($urandom()),
                      1'b0, $urandom_range(0, 99) < 8);
        end
        // bytes past the end of the transfer
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
                send_item(BYTE_W'($urandom()), 1'b0, XFER_SIZE_W'($urandom()), 1'b0,
                          1'($urandom()));
        end
    endtask

    // random starts, sizes and failures with random bytes
    task automatic send_noise_transfer();
        logic [XFER_SIZE_W-1:0] nsize;
        int                     r;
        sender_calm = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            nsize = '0;
        end else if (r < 40) begin
            nsize = XFER_SIZE_W'($urandom_range(1, 30));
        end else begin
            nsize = XFER_SIZE_W'($urandom());
        end
        send_item(BYTE_W'($urandom()), 1'b1, nsize, $urandom_range(0, 9) == 0,
                  1'($urandom()));
        repeat ($urandom_range(0, 40))
            send_item(BYTE_W'($urandom()), 1'b0, XFER_SIZE_W'($urandom()),
                      $urandom_range(0, 9) == 0, 1'($urandom()));
    endtask

    task automatic run_traffic(int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target) begin
            if ($urandom_range(0, 99) < 15) begin
                send_noise_transfer();
            end else begin
                send_frame_transfer();
            end
        end
    endtask

    // idle bytes, failures, empty, oversized and short transfers, tiny frames
    task automatic test_special_cases();
        logic [BYTE_W-1:0] two_frames[17] = '{
            8'h00, 8'h00, 8'h04, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44,
            8'h00, 8'h00, 8'h05, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF
        };
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_item(8'hFF, 1'b0, '0, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 15'h7FFF, 1'b1, 1'b1);
        send_item(8'hA5, 1'b1, 15'd100, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, '0, 1'b0, 1'b0);
        send_item(8'h12, 1'b0, '0, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 15'h7FFF, 1'b0, 1'b0);
        send_item(8'h80, 1'b0, '0, 1'b0, 1'b1);
        send_item(8'h33, 1'b1, 15'd21, 1'b0, 1'b0);
        wait_quiet();
        write_reg(REG_MIN_FRAME, 32'd5);
        write_reg(REG_MAX_FRAME, 32'd64);
        // length 4 frame, then a one-byte payload whose padding runs past the end
        foreach (two_frames[i]) begin
            send_item(two_frames[i], i == 0, 15'd17, 1'b0, 1'b0);
        end
    endtask

    task automatic test_default_limits();
        set_limits(ERR_MASK_RST, int'(MAX_FRAME_RST), int'(MIN_FRAME_RST));
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_traffic(500);
    endtask

    task automatic test_sender_gaps();
        set_limits('0, 16383, 255);
        sender_idle_pct = 87;
        recv_stall_pct  = 0;
        run_traffic(400);
    endtask

    task automatic test_receiver_stalls();
        set_limits(STATUS_W'(1) << $urandom_range(0, 15), 64, 5);
        sender_idle_pct = 0;
        recv_stall_pct  = 87;
        run_traffic(400);
    endtask

    task automatic test_both_idling();
        set_limits(ERR_MASK_RST | 32'h8000_0000, 200, 30);
        sender_idle_pct = 9;
        recv_stall_pct  = 9;
        run_traffic(250);
    endtask

    task automatic test_flag_mask_extremes();
        set_limits(32'hFFFF_FFFF, 100, 18);
        sender_idle_pct = 9;
        recv_stall_pct  = 9;
        run_traffic(100);
        set_limits('0, 100, 18);
        run_traffic(100);
    endtask

    // receiver stall pattern, with calm stretches
    always @(posedge i_clk) begin
        if (stall_epoch == '1) begin
            rx_calm <= ($urandom_range(0, 3) == 0);
        end
        stall_epoch <= stall_epoch + 6'd1;
        i_stall     <= !rx_calm && ($urandom_range(0, 99) < recv_stall_pct);
    end

    // compare each result item with the oldest prediction
    always @(posedge i_clk) begin : check_results
        deframe_out_t want;
        deframe_out_t got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.pl.valid  = o_payload_valid;
            got.pl.data   = o_payload_byte;
            got.pl.first  = o_payload_first;
            got.pl.last   = o_payload_last;
            got.pl.length = o_payload_length;
            got.errors    = o_error_count;
            got.overruns  = o_overrun_count;
            got.transfers = o_transfer_count;
            if (predicted_outputs.size() == 0) begin
                report_mismatch({"unexpected result: ", describe(got)});
            end else begin
                want = predicted_outputs.pop_front();
                if (got.pl.valid !== want.pl.valid || got.pl.data !== want.pl.data
                        || got.pl.first !== want.pl.first || got.pl.last !== want.pl.last
                        || got.pl.length !== want.pl.length
                        || got.errors !== want.errors || got.overruns !== want.overruns
                        || got.transfers !== want.transfers) begin
                    report_mismatch({"expected ", describe(want), "\n  actual   ",
                                     describe(got)});
                end
            end
        end
    end

    // watchdog: too long without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("usb_rx_ethernet_deframer_top: mismatch");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_special_cases();
        test_default_limits();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idling();
        test_flag_mask_extremes();
        wait_quiet();
        if (predicted_outputs.size() != 0) begin
            report_mismatch("results missing at end of run");
        end
        if (mismatch_count == 0) begin
            $display("usb_rx_ethernet_deframer_top: match");
        end else begin
            $display("usb_rx_ethernet_deframer_top: mismatch");
        end
        $finish;
    end

endmodule
